>>> rtl/core/cpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpk_pkg: shared types and constants for the capture ring packetizer
// Beat structs, command and mode codes, ring geometry and header masks.
// ----------------------------------------------------------------------------
package cpk_pkg;

  // ring geometry (powers of two)
  localparam int unsigned RING_SLOTS   = 16;
  localparam int unsigned META_ENTRIES = 4;
  localparam int unsigned HALF_SLOTS   = RING_SLOTS / 2;
  localparam int unsigned HALF_SHIFT   = $clog2(HALF_SLOTS);
  localparam int unsigned SLOT_AW      = $clog2(RING_SLOTS);
  localparam int unsigned META_AW      = $clog2(META_ENTRIES);
  localparam int unsigned META_RAM_WORDS = 2 * META_ENTRIES;
  localparam int unsigned META_ADDR_W  = META_AW + 1;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned META_W       = TIME_W + 1;
  localparam int unsigned CNT_W        = 32;

  // slot header layout
  localparam logic [15:0] SEQ_SLOT_MASK = 16'h0FF8;
  localparam logic [15:0] SEQ_LOW_MASK  = 16'h0007;
  localparam logic [15:0] SEQ_OVF       = 16'h8000;
  localparam int unsigned SEQ_CH_BIT    = 12;

  typedef enum logic [2:0] {
    OP_HALF    = 3'd0,
    OP_POLL    = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_RELEASE = 3'd4
  } cpk_op_e;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_CAPTURING = 2'd1,
    MODE_DRAINING  = 2'd2
  } cpk_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POLL
  } cpk_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        channel;
    logic [15:0] capture_time;
    logic        buffer_index;
    logic        send_ok;
  } cpk_in_t;

  typedef struct packed {
    logic        packet_valid;
    logic [15:0] header_seq;
    logic [15:0] header_time;
    logic        usb_buffer;
    logic [3:0]  payload_slot;
    logic        payload_channel;
    logic [1:0]  mode;
    logic [31:0] overflow_total;
    logic        data_pending;
    logic [1:0]  free_buffers;
  } cpk_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic meta_rd;
    logic commit;
  } cpk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_poll;
    logic out_free;
  } cpk_sts_t;

endpackage

>>> rtl/core/cpk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpk_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cpk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpk_ctrl: packetizer sequencer
// Takes a beat, runs the update, and for polls waits in the poll state on the
// registered metadata read before committing the result.
// ----------------------------------------------------------------------------
module cpk_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpk_pkg::cpk_sts_t sts_i,
  output cpk_pkg::cpk_cmd_t cmd_o
);
  import cpk_pkg::*;

  cpk_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_poll) begin
          cmd_o.meta_rd = 1'b1;
          state_d       = ST_POLL;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_POLL: begin
        // metadata read data is valid from here on
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/cpk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpk_dp: packetizer datapath
// Ring counters, overflow count, buffer bookkeeping, metadata RAM and the
// output register.
// ----------------------------------------------------------------------------
module cpk_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpk_pkg::cpk_in_t  in_data_i,
  input  cpk_pkg::cpk_cmd_t cmd_i,
  output cpk_pkg::cpk_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpk_pkg::cpk_out_t out_data_o
);
  import cpk_pkg::*;

  cpk_in_t          in_q;
  logic [CNT_W-1:0] wr_cnt_q [2];
  logic [CNT_W-1:0] wr_cnt_d [2];
  logic [CNT_W-1:0] rd_cnt_q [2];
  logic [CNT_W-1:0] rd_cnt_d [2];
  logic [CNT_W-1:0] halves_q [2];
  logic [CNT_W-1:0] halves_d [2];
  logic [CNT_W-1:0] ovf_cnt_q, ovf_cnt_d;
  logic [1:0]       free_q, free_d;
  logic             next_buf_q, next_buf_d;
  cpk_mode_e        mode_q, mode_d;
  cpk_out_t         out_q, out_d;
  logic             out_valid_q;

  // channel selection, channel 0 first
  logic [1:0]             avail;
  logic                   sel_found;
  logic                   sel_ch;
  logic [CNT_W-1:0]       sel_slot;
  logic [CNT_W-1:0]       sel_half;
  logic [META_ADDR_W-1:0] meta_raddr;
  logic [META_ADDR_W-1:0] meta_waddr;
  logic [META_W-1:0]      meta_wdata;
  logic [META_W-1:0]      meta_rdata;
  logic                   meta_we;

  // half event terms
  logic [CNT_W-1:0] pending;
  logic             half_ovf;

  // poll terms
  logic             nb;
  logic             stopped;
  logic [15:0]      seq;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      avail[c] = (wr_cnt_q[c] != rd_cnt_q[c]) &&
                 ((rd_cnt_q[c] >> HALF_SHIFT) < halves_q[c]);
    end
  end

  assign sel_found  = avail[0] | avail[1];
  assign sel_ch     = ~avail[0];
  assign sel_slot   = rd_cnt_q[sel_ch];
  assign sel_half   = sel_slot >> HALF_SHIFT;
  assign meta_raddr = {sel_ch, sel_half[META_AW-1:0]};

  assign pending  = wr_cnt_q[in_q.channel] - rd_cnt_q[in_q.channel];
  assign half_ovf = pending > CNT_W'(RING_SLOTS - HALF_SLOTS);

  assign meta_we    = cmd_i.commit && (in_q.cmd == OP_HALF) &&
                      (mode_q == MODE_CAPTURING);
  assign meta_waddr = {in_q.channel, halves_q[in_q.channel][META_AW-1:0]};
  assign meta_wdata = {half_ovf, in_q.capture_time};

  cpk_ram #(
    .WIDTH(META_W),
    .DEPTH(META_RAM_WORDS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .re_i   (cmd_i.meta_rd),
    .raddr_i(meta_raddr),
    .rdata_o(meta_rdata)
  );

  assign seq = (sel_slot[15:0] & SEQ_SLOT_MASK) | (16'(sel_ch) << SEQ_CH_BIT) |
               (sel_slot[15:0] & SEQ_LOW_MASK) |
               (meta_rdata[META_W-1] ? SEQ_OVF : 16'h0000);

  always_comb begin
    wr_cnt_d   = wr_cnt_q;
    rd_cnt_d   = rd_cnt_q;
    halves_d   = halves_q;
    ovf_cnt_d  = ovf_cnt_q;
    free_d     = free_q;
    next_buf_d = next_buf_q;
    mode_d     = mode_q;
    out_d      = '0;
    nb         = next_buf_q;
    stopped    = 1'b0;
    case (in_q.cmd)
      OP_HALF: begin
        if (mode_q == MODE_CAPTURING) begin
          if (half_ovf && (ovf_cnt_q != '1)) begin
            ovf_cnt_d = ovf_cnt_q + CNT_W'(1);
          end
          halves_d[in_q.channel] = halves_q[in_q.channel] + CNT_W'(1);
          wr_cnt_d[in_q.channel] = wr_cnt_q[in_q.channel] + CNT_W'(HALF_SLOTS);
        end
      end
      OP_POLL: begin
        if (sel_found) begin
          if (!free_q[nb]) begin
            nb = ~nb;
          end
          next_buf_d = nb;
          if (!free_q[nb] || !in_q.send_ok) begin
            stopped = 1'b1;
          end else begin
            out_d.packet_valid    = 1'b1;
            out_d.header_seq      = seq;
            out_d.header_time     = meta_rdata[TIME_W-1:0];
            out_d.usb_buffer      = nb;
            out_d.payload_slot    = 4'(sel_slot[SLOT_AW-1:0]);
            out_d.payload_channel = sel_ch;
            free_d[nb]            = 1'b0;
            rd_cnt_d[sel_ch]      = sel_slot + CNT_W'(1);
            next_buf_d            = ~nb;
          end
        end
        if (stopped) begin
          if (mode_q != MODE_IDLE) begin
            mode_d = MODE_DRAINING;
          end
        end else if ((mode_q == MODE_DRAINING) && (wr_cnt_d[0] == rd_cnt_d[0]) &&
                     (wr_cnt_d[1] == rd_cnt_d[1])) begin
          mode_d = MODE_IDLE;
        end
      end
      OP_START: begin
        wr_cnt_d  = '{default: '0};
        rd_cnt_d  = '{default: '0};
        halves_d  = '{default: '0};
        ovf_cnt_d = '0;
        free_d    = 2'b11;
        mode_d    = MODE_CAPTURING;
      end
      OP_STOP: begin
        if (mode_q != MODE_IDLE) begin
          mode_d = MODE_DRAINING;
        end
      end
      OP_RELEASE: begin
        free_d[in_q.buffer_index] = 1'b1;
      end
      default: begin
      end
    endcase
    out_d.mode           = mode_d;
    out_d.overflow_total = ovf_cnt_d;
    out_d.data_pending   = (wr_cnt_d[0] != rd_cnt_d[0]) ||
                           (wr_cnt_d[1] != rd_cnt_d[1]);
    out_d.free_buffers   = free_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q    <= '{default: '0};
      rd_cnt_q    <= '{default: '0};
      halves_q    <= '{default: '0};
      ovf_cnt_q   <= '0;
      free_q      <= 2'b11;
      next_buf_q  <= 1'b0;
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        wr_cnt_q   <= wr_cnt_d;
        rd_cnt_q   <= rd_cnt_d;
        halves_q   <= halves_d;
        ovf_cnt_q  <= ovf_cnt_d;
        free_q     <= free_d;
        next_buf_q <= next_buf_d;
        mode_q     <= mode_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_poll  = (in_q.cmd == OP_POLL);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

>>> rtl/core/capture_ring_packetizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_ring_packetizer_unit: two-channel capture ring packetizer
// Bookkeeping for capture rings drained into two ping-pong USB buffers:
// half events, polls, host start/stop and buffer releases, one status beat
// per command.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   in        input       in_valid_i/in_ready_o   in_data_i  (cpk_in_t)
//   out       output      out_valid_o/out_ready_i out_data_o (cpk_out_t)
//
// one beat in gives one beat out. a non-poll command is committed from the
// exec state, a poll from the poll state after the registered metadata RAM
// read. the next beat is taken in the cycle after the result is committed.
// a result stalled at the output holds the sequencer; one more input beat
// can be accepted meanwhile. reset brings the rings empty, both buffers free
// and the mode idle; the metadata RAM is not cleared.
module capture_ring_packetizer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpk_pkg::cpk_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpk_pkg::cpk_out_t out_data_o
);
  import cpk_pkg::*;

  cpk_cmd_t cmd;
  cpk_sts_t sts;

  cpk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cpk_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
